@@ hw/rtl/pe_rhe_pkg.sv @@
// Package with constants, status codes and sequencer states of the rich header extractor.
`timescale 1ns / 1ps
`default_nettype none
package pe_rhe_pkg;

    localparam int BUF_BYTES   = 512;
    localparam int ADDR_W      = $clog2(BUF_BYTES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int OFF_W       = 20;
    localparam int MAX_ENTRIES = 62;
    localparam int OUT_DATA_W  = 120;

    localparam logic [15:0] MZ_MAGIC     = 16'h5a4d;
    localparam logic [31:0] PE_SIGNATURE = 32'h0000_4550;
    localparam logic [31:0] RICH_MARKER  = 32'h6863_6952;
    localparam logic [31:0] DANS_TOKEN   = 32'h536E_6144;
    localparam logic [OFF_W-1:0] OFF_RELOCS    = 20'h6;
    localparam logic [OFF_W-1:0] OFF_PARAS     = 20'h8;
    localparam logic [OFF_W-1:0] OFF_RELOC_OFF = 20'h18;
    localparam logic [OFF_W-1:0] OFF_PE_OFF    = 20'h3c;

    typedef enum logic [3:0] {
        ST_ENTRY       = 4'd0,
        ST_NO_ENTRIES  = 4'd1,
        ST_NO_MZ       = 4'd2,
        ST_FEW_PARAS   = 4'd3,
        ST_PE_OFF_LOW  = 4'd4,
        ST_NO_PE       = 4'd5,
        ST_NO_RICH     = 4'd6,
        ST_NO_DANS     = 4'd7,
        ST_END_PAST_PE = 4'd8,
        ST_TRUNCATED   = 4'd9
    } status_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_FETCH,
        S_MZ,
        S_RELOCS,
        S_PARAS,
        S_RELOC_OFF,
        S_PE_OFF,
        S_PE_SIG,
        S_MACH,
        S_SC1,
        S_SC1_CHK,
        S_KEY,
        S_SC2,
        S_SC2_CHK,
        S_COUNT,
        S_E_COMP,
        S_E_CNT,
        S_E_OUT,
        S_WAIT
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/pe_rhe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pe_rhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/pe_rich_header_extractor.sv @@
// Top level of the executable rich header extractor: byte loader and analysis sequencer.
//
// The input channel takes the file one byte per word (s_tdata), from offset zero,
// with s_tlast on the final byte; one word is accepted per cycle while loading.
// The first 512 bytes are kept in a byte RAM; later bytes are dropped.
// After the last byte, s_tready stays low while a sequencer walks the headers,
// scans for the Rich marker and the masked DanS token, and emits results.
// Every header read goes through one byte fetcher that reads the RAM one byte
// per cycle, so a word read fetches two bytes and a dword read four. A pre-pass
// counts the entries before any is emitted, and each emitted entry then waits
// in the wait state until the receiver takes it.
// Results leave on the output channel one word each, m_tlast marking the last
// result of the file. A stalled receiver simply holds the sequencer in its
// wait state with the result word stable. Reset (aresetn low, synchronous)
// returns the block to loading with an empty byte count; RAM contents are
// not cleared, as only bytes of the current file are ever read.
`timescale 1ns / 1ps
`default_nettype none
module pe_rich_header_extractor (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // end_of_file
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[3:0], machine_id[19:4], comp_id[51:20], product_id[67:52],
    // build_number[83:68], use_count[115:84], zero pad[119:116]
    output logic [pe_rhe_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic              m_tlast    // last_result
);
    localparam int OFF_W = pe_rhe_pkg::OFF_W;
    localparam int CNT_W = pe_rhe_pkg::CNT_W;
    localparam int ADDR_W = pe_rhe_pkg::ADDR_W;

    pe_rhe_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next, kept_reg, kept_next;
    logic [OFF_W-1:0] foff_reg, foff_next;
    logic [2:0]       flen_reg, flen_next, idx_reg, idx_next;
    logic [31:0]      acc_reg, acc_next;
    logic [15:0]      relocs_reg, relocs_next, paras_reg, paras_next;
    logic [15:0]      roff_reg, roff_next, peoff_reg, peoff_next, mach_reg, mach_next;
    logic [OFF_W-1:0] stub_reg, stub_next, ptr_reg, ptr_next, rich_reg, rich_next;
    logic [OFF_W-1:0] dans_reg, dans_next, endp_reg, endp_next;
    logic [31:0]      key_reg, key_next, comp_reg, comp_next;
    logic [5:0]       n_reg, n_next, total_reg, total_next;

    logic [3:0]  ostat_reg, ostat_next;
    logic [15:0] omach_reg, omach_next;
    logic [31:0] ocomp_reg, ocomp_next, ocnt_reg, ocnt_next;
    logic        olast_reg, olast_next;

    logic        emit_st;
    pe_rhe_pkg::status_t emit_code;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;
    logic [OFF_W-1:0]  pe_off_ext, stub_sum, stub_up;
    logic [OFF_W:0]    fetch_end;
    logic [1:0]        byte_sel;

    assign pe_off_ext = {{(OFF_W-16){1'b0}}, peoff_reg};
    assign stub_sum   = {{(OFF_W-16){1'b0}}, roff_reg}
                      + {{(OFF_W-18){1'b0}}, relocs_reg, 2'b00};
    assign stub_up    = (stub_sum + OFF_W'(15)) & ~OFF_W'(15);
    assign fetch_end  = {1'b0, foff_reg} + {{(OFF_W-2){1'b0}}, flen_reg};
    assign byte_sel   = 2'(idx_reg - 3'd1);

    pe_rhe_ram #(
        .WIDTH(8),
        .DEPTH(pe_rhe_pkg::BUF_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and RAM port controls.
    always_comb begin
        s_tready  = (state_reg == pe_rhe_pkg::S_LOAD);
        m_tvalid  = (state_reg == pe_rhe_pkg::S_WAIT);
        ram_we    = s_tvalid && s_tready && (cnt_reg < CNT_W'(pe_rhe_pkg::BUF_BYTES));
        ram_waddr = cnt_reg[ADDR_W-1:0];
        ram_raddr = ADDR_W'(foff_reg + {{(OFF_W-3){1'b0}}, idx_reg});
    end

    assign m_tdata = {4'b0000, ocnt_reg, ocomp_reg[15:0], ocomp_reg[31:16], ocomp_reg,
                      omach_reg, ostat_reg};
    assign m_tlast = olast_reg;

    // Sequencer next state and datapath.
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        kept_next  = kept_reg;
        foff_next  = foff_reg;
        flen_next  = flen_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        relocs_next = relocs_reg;
        paras_next = paras_reg;
        roff_next  = roff_reg;
        peoff_next = peoff_reg;
        mach_next  = mach_reg;
        stub_next  = stub_reg;
        ptr_next   = ptr_reg;
        rich_next  = rich_reg;
        dans_next  = dans_reg;
        endp_next  = endp_reg;
        key_next   = key_reg;
        comp_next  = comp_reg;
        n_next     = n_reg;
        total_next = total_reg;
        ostat_next = ostat_reg;
        omach_next = omach_reg;
        ocomp_next = ocomp_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        emit_st    = 1'b0;
        emit_code  = pe_rhe_pkg::ST_TRUNCATED;

        case (state_reg)
            pe_rhe_pkg::S_LOAD: begin
                if (s_tvalid) begin
                    if (cnt_reg < CNT_W'(pe_rhe_pkg::BUF_BYTES)) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        kept_next  = cnt_next;
                        cnt_next   = '0;
                        foff_next  = '0;
                        flen_next  = 3'd2;
                        idx_next   = '0;
                        ret_next   = pe_rhe_pkg::S_MZ;
                        state_next = pe_rhe_pkg::S_FETCH;
                    end
                end
            end
            pe_rhe_pkg::S_FETCH: begin
                if (idx_reg == 3'd0) begin
                    acc_next = '0;
                    if (fetch_end > {1'b0, {(OFF_W-CNT_W){1'b0}}, kept_reg}) begin
                        emit_st = 1'b1;
                    end else begin
                        idx_next = 3'd1;
                    end
                end else begin
                    acc_next[8*byte_sel +: 8] = ram_rdata;
                    if (idx_reg == flen_reg) begin
                        state_next = ret_reg;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            pe_rhe_pkg::S_MZ: begin
                if (acc_reg[15:0] != pe_rhe_pkg::MZ_MAGIC) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_NO_MZ;
                end else begin
                    foff_next = pe_rhe_pkg::OFF_RELOCS;
                    idx_next  = '0;
                    ret_next  = pe_rhe_pkg::S_RELOCS;
                    state_next = pe_rhe_pkg::S_FETCH;
                end
            end
            pe_rhe_pkg::S_RELOCS: begin
                relocs_next = acc_reg[15:0];
                foff_next   = pe_rhe_pkg::OFF_PARAS;
                idx_next    = '0;
                ret_next    = pe_rhe_pkg::S_PARAS;
                state_next  = pe_rhe_pkg::S_FETCH;
            end
            pe_rhe_pkg::S_PARAS: begin
                paras_next = acc_reg[15:0];
                if (acc_reg[15:0] < 16'd4) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_FEW_PARAS;
                end else begin
                    foff_next  = pe_rhe_pkg::OFF_RELOC_OFF;
                    idx_next   = '0;
                    ret_next   = pe_rhe_pkg::S_RELOC_OFF;
                    state_next = pe_rhe_pkg::S_FETCH;
                end
            end
            pe_rhe_pkg::S_RELOC_OFF: begin
                roff_next  = acc_reg[15:0];
                foff_next  = pe_rhe_pkg::OFF_PE_OFF;
                idx_next   = '0;
                ret_next   = pe_rhe_pkg::S_PE_OFF;
                state_next = pe_rhe_pkg::S_FETCH;
            end
            pe_rhe_pkg::S_PE_OFF: begin
                peoff_next = acc_reg[15:0];
                if ({{(OFF_W-16){1'b0}}, acc_reg[15:0]}
                        < {paras_reg, 4'b0000}) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_PE_OFF_LOW;
                end else begin
                    foff_next  = {{(OFF_W-16){1'b0}}, acc_reg[15:0]};
                    flen_next  = 3'd4;
                    idx_next   = '0;
                    ret_next   = pe_rhe_pkg::S_PE_SIG;
                    state_next = pe_rhe_pkg::S_FETCH;
                end
            end
            pe_rhe_pkg::S_PE_SIG: begin
                if (acc_reg != pe_rhe_pkg::PE_SIGNATURE) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_NO_PE;
                end else begin
                    foff_next  = pe_off_ext + OFF_W'(4);
                    flen_next  = 3'd2;
                    idx_next   = '0;
                    ret_next   = pe_rhe_pkg::S_MACH;
                    state_next = pe_rhe_pkg::S_FETCH;
                end
            end
            pe_rhe_pkg::S_MACH: begin
                mach_next  = acc_reg[15:0];
                stub_next  = stub_up;
                ptr_next   = stub_up;
                flen_next  = 3'd4;
                state_next = pe_rhe_pkg::S_SC1;
            end
            pe_rhe_pkg::S_SC1: begin
                if (ptr_reg >= pe_off_ext) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_NO_RICH;
                end else begin
                    foff_next  = ptr_reg;
                    idx_next   = '0;
                    ret_next   = pe_rhe_pkg::S_SC1_CHK;
                    state_next = pe_rhe_pkg::S_FETCH;
                end
            end
            pe_rhe_pkg::S_SC1_CHK: begin
                if (acc_reg == pe_rhe_pkg::RICH_MARKER) begin
                    rich_next  = ptr_reg + OFF_W'(4);
                    foff_next  = ptr_reg + OFF_W'(4);
                    idx_next   = '0;
                    ret_next   = pe_rhe_pkg::S_KEY;
                    state_next = pe_rhe_pkg::S_FETCH;
                end else begin
                    ptr_next   = ptr_reg + OFF_W'(4);
                    state_next = pe_rhe_pkg::S_SC1;
                end
            end
            pe_rhe_pkg::S_KEY: begin
                key_next   = acc_reg;
                ptr_next   = stub_reg;
                state_next = pe_rhe_pkg::S_SC2;
            end
            pe_rhe_pkg::S_SC2: begin
                if (ptr_reg >= pe_off_ext) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_NO_DANS;
                end else begin
                    foff_next  = ptr_reg;
                    idx_next   = '0;
                    ret_next   = pe_rhe_pkg::S_SC2_CHK;
                    state_next = pe_rhe_pkg::S_FETCH;
                end
            end
            pe_rhe_pkg::S_SC2_CHK: begin
                if ((acc_reg ^ key_reg) == pe_rhe_pkg::DANS_TOKEN) begin
                    // A token at file offset zero does not count as a hit.
                    if (ptr_reg == '0) begin
                        emit_st   = 1'b1;
                        emit_code = pe_rhe_pkg::ST_NO_DANS;
                    end else if (rich_reg + OFF_W'(4) > pe_off_ext) begin
                        emit_st   = 1'b1;
                        emit_code = pe_rhe_pkg::ST_END_PAST_PE;
                    end else begin
                        dans_next  = ptr_reg;
                        endp_next  = rich_reg - OFF_W'(4);
                        ptr_next   = ptr_reg + OFF_W'(16);
                        n_next     = '0;
                        state_next = pe_rhe_pkg::S_COUNT;
                    end
                end else begin
                    ptr_next   = ptr_reg + OFF_W'(4);
                    state_next = pe_rhe_pkg::S_SC2;
                end
            end
            pe_rhe_pkg::S_COUNT: begin
                // Count the entries first: a read past the kept bytes on any
                // entry replaces the whole entry list with one status word.
                if (ptr_reg < endp_reg && n_reg < 6'(pe_rhe_pkg::MAX_ENTRIES)) begin
                    n_next   = n_reg + 6'd1;
                    ptr_next = ptr_reg + OFF_W'(8);
                end else if (n_reg == '0) begin
                    emit_st   = 1'b1;
                    emit_code = pe_rhe_pkg::ST_NO_ENTRIES;
                end else if (ptr_reg > {{(OFF_W-CNT_W){1'b0}}, kept_reg}) begin
                    emit_st = 1'b1;
                end else begin
                    total_next = n_reg;
                    n_next     = '0;
                    ptr_next   = dans_reg + OFF_W'(16);
                    state_next = pe_rhe_pkg::S_E_COMP;
                end
            end
            pe_rhe_pkg::S_E_COMP: begin
                foff_next  = ptr_reg;
                idx_next   = '0;
                ret_next   = pe_rhe_pkg::S_E_CNT;
                state_next = pe_rhe_pkg::S_FETCH;
            end
            pe_rhe_pkg::S_E_CNT: begin
                comp_next  = acc_reg ^ key_reg;
                foff_next  = ptr_reg + OFF_W'(4);
                idx_next   = '0;
                ret_next   = pe_rhe_pkg::S_E_OUT;
                state_next = pe_rhe_pkg::S_FETCH;
            end
            pe_rhe_pkg::S_E_OUT: begin
                ostat_next = pe_rhe_pkg::ST_ENTRY;
                omach_next = mach_reg;
                ocomp_next = comp_reg;
                ocnt_next  = acc_reg ^ key_reg;
                olast_next = (n_reg + 6'd1 == total_reg);
                n_next     = n_reg + 6'd1;
                ptr_next   = ptr_reg + OFF_W'(8);
                state_next = pe_rhe_pkg::S_WAIT;
            end
            pe_rhe_pkg::S_WAIT: begin
                if (m_tready) begin
                    state_next = olast_reg ? pe_rhe_pkg::S_LOAD : pe_rhe_pkg::S_E_COMP;
                end
            end
            default: begin
                state_next = pe_rhe_pkg::S_LOAD;
            end
        endcase

        if (emit_st) begin
            ostat_next = emit_code;
            omach_next = (emit_code == pe_rhe_pkg::ST_NO_ENTRIES) ? mach_reg : 16'h0000;
            ocomp_next = '0;
            ocnt_next  = '0;
            olast_next = 1'b1;
            state_next = pe_rhe_pkg::S_WAIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pe_rhe_pkg::S_LOAD;
            ret_reg   <= pe_rhe_pkg::S_LOAD;
            cnt_reg   <= '0;
            kept_reg  <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            total_reg <= '0;
            olast_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            kept_reg  <= kept_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            total_reg <= total_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge aclk) begin
        foff_reg   <= foff_next;
        flen_reg   <= flen_next;
        acc_reg    <= acc_next;
        relocs_reg <= relocs_next;
        paras_reg  <= paras_next;
        roff_reg   <= roff_next;
        peoff_reg  <= peoff_next;
        mach_reg   <= mach_next;
        stub_reg   <= stub_next;
        ptr_reg    <= ptr_next;
        rich_reg   <= rich_next;
        dans_reg   <= dans_next;
        endp_reg   <= endp_next;
        key_reg    <= key_next;
        comp_reg   <= comp_next;
        ostat_reg  <= ostat_next;
        omach_reg  <= omach_next;
        ocomp_reg  <= ocomp_next;
        ocnt_reg   <= ocnt_next;
    end
endmodule
`default_nettype wire

@@ tb/pe_rhe_checker.sv @@
// Checker that predicts and compares the result words of the rich header extractor.
`timescale 1ns / 1ps
module pe_rhe_checker
    import pe_rhe_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  m_tlast,
    output int                         errors,
    output int                         pending
);

    typedef struct {
        status_t     status;
        logic [15:0] machine;
        logic [31:0] comp;
        logic [31:0] count;
        logic        last;
    } rich_result_t;

    logic [7:0]   file_bytes [0:BUF_BYTES-1];
    int unsigned  fill_count = 0;
    int unsigned  kept = 0;
    bit           read_fault;
    rich_result_t expected_results [$];

    assign pending = expected_results.size();
    initial errors = 0;

    // Little-endian read of nb bytes; a read past the kept bytes flags a fault.
    function automatic logic [31:0] peek(int unsigned off, int unsigned nb);
        logic [31:0] v;
        v = '0;
        if (off + nb > kept) begin
            read_fault = 1'b1;
            return '0;
        end
        for (int k = 0; k < nb; k++) v[8*k +: 8] = file_bytes[off + k];
        return v;
    endfunction

    function automatic void push(status_t st, logic [15:0] mach, logic [31:0] comp,
                                 logic [31:0] cnt, logic last);
        rich_result_t r;
        r.status = st;
        r.machine = mach;
        r.comp = comp;
        r.count = cnt;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    task automatic predict_file();
        int unsigned  relocs, paras, reloc_off, pe_off, stub, rich, dans, endp, cur;
        logic [15:0]  mach;
        logic [31:0]  key, v;
        bit           found;
        rich_result_t entries [$];
        read_fault = 1'b0;
        if (peek(0, 2) != MZ_MAGIC) begin
            push(read_fault ? ST_TRUNCATED : ST_NO_MZ, '0, '0, '0, 1'b1);
            return;
        end
        relocs = peek(OFF_RELOCS, 2);
        paras = peek(OFF_PARAS, 2);
        if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end
        if (paras < 4) begin push(ST_FEW_PARAS, '0, '0, '0, 1'b1); return; end
        reloc_off = peek(OFF_RELOC_OFF, 2);
        pe_off = peek(OFF_PE_OFF, 2);
        if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end
        if (pe_off < paras * 16) begin push(ST_PE_OFF_LOW, '0, '0, '0, 1'b1); return; end
        if (peek(pe_off, 4) != PE_SIGNATURE) begin
            push(read_fault ? ST_TRUNCATED : ST_NO_PE, '0, '0, '0, 1'b1);
            return;
        end
        mach = peek(pe_off + 4, 2);
        if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end

        // The stub begins at the next paragraph boundary after the relocation table.
        stub = reloc_off + 4 * relocs;
        if (stub % 16 != 0) stub += 16 - stub % 16;

        found = 1'b0;
        rich = 0;
        for (int unsigned i = stub; i < pe_off; i += 4) begin
            v = peek(i, 4);
            if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end
            if (v == RICH_MARKER) begin rich = i + 4; found = 1'b1; break; end
        end
        if (!found) begin push(ST_NO_RICH, '0, '0, '0, 1'b1); return; end
        key = peek(rich, 4);
        if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end

        found = 1'b0;
        dans = 0;
        for (int unsigned i = stub; i < pe_off; i += 4) begin
            v = peek(i, 4) ^ key;
            if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end
            if (v == DANS_TOKEN) begin dans = i; found = 1'b1; break; end
        end
        // A token at offset zero is treated as missing.
        if (!found || dans == 0) begin push(ST_NO_DANS, '0, '0, '0, 1'b1); return; end
        rich += 4;
        if (rich > pe_off) begin push(ST_END_PAST_PE, '0, '0, '0, 1'b1); return; end

        endp = rich - 8;
        cur = dans + 16;
        while (cur < endp && entries.size() < MAX_ENTRIES) begin
            rich_result_t e;
            e.status = ST_ENTRY;
            e.machine = mach;
            e.comp = peek(cur, 4) ^ key;
            e.count = peek(cur + 4, 4) ^ key;
            e.last = 1'b0;
            if (read_fault) begin push(ST_TRUNCATED, '0, '0, '0, 1'b1); return; end
            entries.push_back(e);
            cur += 8;
        end
        if (entries.size() == 0) begin push(ST_NO_ENTRIES, mach, '0, '0, 1'b1); return; end
        entries[entries.size() - 1].last = 1'b1;
        foreach (entries[k]) expected_results.push_back(entries[k]);
    endtask

    // Input side: store the byte, and predict the whole file on its last word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_count = 0;
        end else if (s_tvalid && s_tready) begin
            if (fill_count < BUF_BYTES) begin
                file_bytes[fill_count] = s_tdata;
                fill_count++;
            end
            if (s_tlast) begin
                kept = fill_count;
                predict_file();
                fill_count = 0;
            end
        end
    end

    // Output side: compare each accepted word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no expectation: %h", m_tdata);
                errors++;
            end else begin
                rich_result_t e;
                e = expected_results.pop_front();
                if (m_tdata[3:0] != e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[19:4] != e.machine) begin
                    $error("machine_id: expected %h, got %h", e.machine, m_tdata[19:4]);
                    errors++;
                end
                if (m_tdata[51:20] != e.comp) begin
                    $error("comp_id: expected %h, got %h", e.comp, m_tdata[51:20]);
                    errors++;
                end
                if (m_tdata[67:52] != e.comp[31:16]) begin
                    $error("product_id: expected %h, got %h", e.comp[31:16], m_tdata[67:52]);
                    errors++;
                end
                if (m_tdata[83:68] != e.comp[15:0]) begin
                    $error("build_number: expected %h, got %h", e.comp[15:0], m_tdata[83:68]);
                    errors++;
                end
                if (m_tdata[115:84] != e.count) begin
                    $error("use_count: expected %h, got %h", e.count, m_tdata[115:84]);
                    errors++;
                end
                if (m_tlast != e.last) begin
                    $error("last_result: expected %0d, got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the rich header extractor testbench: clock, reset, file stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import pe_rhe_pkg::*;

    // Kinds of file image that the stimulus builds; most are a sound header
    // with one deliberate defect so that each exit of the analysis is reached.
    typedef enum int {
        M_GOOD, M_BAD_MZ, M_FEW_PARAS, M_PE_LOW, M_BAD_PE, M_NO_RICH, M_NO_DANS,
        M_DANS_ZERO, M_END_PAST, M_TRUNC, M_NOISE, M_BIG, M_PE_FAR, M_TINY
    } file_kind_t;

    localparam int IDLE_LIMIT = 50000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    int                    errors;
    int                    pending;

    // The file under construction and its length in bytes.
    logic [7:0]  img [0:767];
    int unsigned img_len;
    // When set, neither side idles, so long back-to-back stretches occur.
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pe_rich_header_extractor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    pe_rhe_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .errors(errors), .pending(pending)
    );

    // Mostly no gap, often a short one, rarely a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void put16(int unsigned off, logic [15:0] v);
        img[off] = v[7:0];
        img[off + 1] = v[15:8];
    endfunction

    function automatic void put32(int unsigned off, logic [31:0] v);
        for (int k = 0; k < 4; k++) img[off + k] = v[8*k +: 8];
    endfunction

    // Builds a file: MZ header of four paragraphs, relocation table at 0x40,
    // the masked DanS block at the stub start, entries, the Rich marker and
    // key, then the PE signature with random machine bytes. The kind adds one defect.
    function automatic void build_file(file_kind_t kind);
        int unsigned relocs, stub, n_ent, rich_at, pe;
        logic [31:0] key;
        relocs = $urandom_range(0, 3);
        n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 6);
        key = $urandom;
        for (int k = 0; k < 768; k++) img[k] = $urandom;
        put16(0, MZ_MAGIC);
        put16(OFF_RELOCS, relocs);
        put16(OFF_PARAS, 16'd4);
        put16(OFF_RELOC_OFF, 16'h40);
        stub = 32'h40 + 4 * relocs;
        if (stub % 16 != 0) stub += 16 - stub % 16;
        if (kind == M_END_PAST) key = PE_SIGNATURE;
        if (kind == M_DANS_ZERO) begin
            // Scanning from offset zero makes the first dword the DanS hit.
            put16(OFF_RELOCS, 16'd0);
            put16(OFF_RELOC_OFF, 16'd0);
            key = {img[3], img[2], img[1], img[0]} ^ DANS_TOKEN;
            rich_at = 32'h40;
        end else begin
            put32(stub, DANS_TOKEN ^ key);
            for (int k = 1; k < 4; k++) put32(stub + 4 * k, key);
            rich_at = stub + 16 + 8 * n_ent;
        end
        put32(rich_at, RICH_MARKER);
        if (kind == M_END_PAST) begin
            // The key dword is the PE signature itself, so the end lies past it.
            pe = rich_at + 4;
        end else begin
            put32(rich_at + 4, key);
            pe = rich_at + 8 + 4 * $urandom_range(0, 2);
        end
        put32(pe, PE_SIGNATURE);
        put16(OFF_PE_OFF, pe);
        img_len = pe + 6 + $urandom_range(0, 8);
        case (kind)
            M_BAD_MZ:    img[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            M_FEW_PARAS: put16(OFF_PARAS, $urandom_range(0, 3));
            M_PE_LOW:    put16(OFF_PE_OFF, $urandom_range(0, 63));
            M_BAD_PE:    img[pe + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            M_NO_RICH:   img[rich_at + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            M_NO_DANS:   img[stub + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            M_TRUNC:     img_len = $urandom_range(1, img_len - 1);
            M_BIG:       img_len = $urandom_range(513, 768);
            M_PE_FAR:    put16(OFF_PE_OFF, $urandom_range(505, 16'hffff));
            M_TINY:      img_len = $urandom_range(1, 2);
            M_NOISE: begin
                img_len = $urandom_range(1, 120);
                if ($urandom_range(0, 1) == 1) put16(0, MZ_MAGIC);
            end
            default: ;
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_file(file_kind_t kind);
        build_file(kind);
        quiet = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 0; k < img_len; k++) send_byte(img[k], k == img_len - 1);
    endtask

    // Receiver: ready most of the time, with stalls of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned total;
        file_kind_t  kind;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Files until about 350 bytes have been sent: mostly sound files with
        // random content, the rest with one defect each.
        total = 0;
        while (total < 350) begin
            if ($urandom_range(0, 99) < 55) kind = M_GOOD;
            else kind = file_kind_t'($urandom_range(M_BAD_MZ, M_TINY));
            send_file(kind);
            total += img_len;
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        // Wait until every expected result word has been seen.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
